[src/nta_pkg.sv]
// Package for the NTC temperature alarm.
// Holds beat types, register indexes and fixed-point constants; no dependencies.
package nta_pkg;

    localparam int ADC_BITS = 12;
    localparam int CODE_W  = ADC_BITS;
    localparam int TIME_W  = 32;
    localparam int DEB_W   = 20;
    localparam int STEP_W  = 5;
    localparam int TEMP_W  = 12;
    localparam int SP_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd1;

    localparam logic [DEB_W-1:0]  DEB_RESET  = 20'd150000;
    localparam logic [STEP_W-1:0] STEP_RESET = 5'd5;
    localparam logic signed [SP_W-1:0] SP_RESET = 8'sd25;
    localparam logic signed [9:0] SP_MIN = -10'sd40;
    localparam logic signed [9:0] SP_MAX = 10'sd125;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -12'sd400;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sd1250;

    localparam logic [63:0] INV_T0_FULL = (64'd109951162777600 + 64'd14907) / 64'd29815;
    localparam logic [31:0] INV_T0_Q40  = INV_T0_FULL[31:0];
    localparam logic [63:0] LOG_K_FULL  = (64'd2977044472 * 64'd256 + 64'd1975) / 64'd3950;
    localparam logic [27:0] LOG_K       = LOG_K_FULL[27:0];

    // dividend 100 * 2^40, top bits preloaded, 20 quotient bits remain
    localparam logic [34:0] DIV_INIT = 35'd104857600;
    localparam int          DIV_STEPS = 20;

    localparam logic [19:0] V_LO   = 20'd23310;
    localparam logic [19:0] V_HI   = 20'd39819;
    localparam logic [14:0] X_MAX  = 15'd16509;
    localparam logic [27:0] RECIP10 = 28'd52429;

    typedef struct packed {
        logic [TIME_W-1:0] time_us;
        logic [CODE_W-1:0] adc_code;
        logic              inc_request;
        logic              dec_request;
    } t_in_beat;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_tenths;
        logic signed [SP_W-1:0]   alarm_setpoint;
        logic                     alarm_active;
        logic [3:0]               led_bar;
        logic                     sensor_fault;
    } t_out_beat;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOGA  = 7'b0000010,
        S_LOGB  = 7'b0000100,
        S_SCALE = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_TEN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

endpackage

[src/ntc_temperature_alarm.sv]
// NTC temperature alarm top level: beta-equation conversion, setpoint buttons, alarm bar.
// Depends on nta_pkg.
//
// One input beat is taken at a time and the block stalls its input until the result is
// handed to the output register, which lets the next beat enter while a result waits.
// A normal reading goes from acceptance to the output register in 32 squaring
// steps for the two base-2 logarithms, one scaling step, 20 restoring division steps, one
// step for the conversion to tenths and one to load the output register; the squaring,
// scaling and tenths steps share one 28x28 multiplier. Rail codes skip straight to the
// output load. Configuration writes are always ready.
module ntc_temperature_alarm (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  nta_pkg::t_in_beat                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output nta_pkg::t_out_beat               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nta_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nta_pkg::DEB_W-1:0]        i_cfg_data
);
    import nta_pkg::*;

    localparam logic [16:0] FULL_WIDE = (17'd1 << ADC_BITS) - 17'd1;
    localparam logic [15:0] FULL_CODE = FULL_WIDE[15:0];

    t_state r_state, n_state;

    logic [DEB_W-1:0]  r_deb;
    logic [STEP_W-1:0] r_step;
    logic signed [SP_W-1:0] r_sp, n_sp;
    logic r_raise_pend, n_raise_pend, r_lower_pend, n_lower_pend;
    logic [TIME_W-1:0] r_last_raise, n_last_raise, r_last_lower, n_last_lower;

    logic [15:0] r_code, n_code;
    logic [16:0] r_m, n_m;
    logic [15:0] r_frac, n_frac;
    logic [3:0]  r_p, n_p;
    logic [19:0] r_la, n_la;
    logic [4:0]  r_cnt, n_cnt;
    logic [20:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic [34:0] r_div, n_div;
    logic [34:0] r_rem, n_rem;
    logic [19:0] r_q, n_q;
    logic signed [TEMP_W-1:0] r_tenths, n_tenths;
    logic        r_fault, n_fault;
    logic        r_out_valid, n_out_valid;
    t_out_beat   r_out, n_out;

    logic [27:0] mul_a, mul_b;
    logic [55:0] mul_p;

    function automatic logic [3:0] top_bit(input logic [15:0] x);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 1; i < 16; i++) begin
            if (x[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

    function automatic logic signed [SP_W-1:0] clamp_sp(input logic signed [9:0] s);
        logic signed [9:0] c;
        c = s;
        if (s < SP_MIN) begin
            c = SP_MIN;
        end else if (s > SP_MAX) begin
            c = SP_MAX;
        end
        return c[SP_W-1:0];
    endfunction

    assign mul_p       = mul_a * mul_b;
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    logic        in_take;
    logic        raise_ok, lower_ok, raise_p, lower_p;
    logic signed [9:0] sp_mid;
    logic [3:0]  norm_p;
    logic [15:0] norm_x;
    logic [17:0] sq;
    logic        sq_bit;
    logic [15:0] frac_nx;
    logic signed [20:0] d_log;
    logic [33:0] scaled;
    logic signed [35:0] inv_t;
    logic [35:0] rem2;
    logic        q_bit;
    logic [14:0] x_ten;
    logic signed [12:0] sp10, gap;

    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_raise_pend = r_raise_pend;
        n_lower_pend = r_lower_pend;
        n_last_raise = r_last_raise;
        n_last_lower = r_last_lower;
        n_code       = r_code;
        n_m          = r_m;
        n_frac       = r_frac;
        n_p          = r_p;
        n_la         = r_la;
        n_cnt        = r_cnt;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_div        = r_div;
        n_rem        = r_rem;
        n_q          = r_q;
        n_tenths     = r_tenths;
        n_fault      = r_fault;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        in_take  = i_in_valid && !o_in_stall;
        raise_p  = r_raise_pend || i_in_data.inc_request;
        lower_p  = r_lower_pend || i_in_data.dec_request;
        raise_ok = raise_p &&
                   ((i_in_data.time_us - r_last_raise) > {12'd0, r_deb});
        lower_ok = lower_p &&
                   ((i_in_data.time_us - r_last_lower) > {12'd0, r_deb});
        sp_mid   = raise_ok ? 10'(clamp_sp(10'(r_sp) + $signed({5'd0, r_step})))
                            : 10'(r_sp);

        norm_x = (r_state == S_IDLE) ? 16'(i_in_data.adc_code) : FULL_CODE - r_code;
        norm_p = top_bit(norm_x);

        mul_a = {11'd0, r_m};
        mul_b = {11'd0, r_m};
        x_ten = 15'd0;
        if (r_q < V_LO) begin
            x_ten = 15'd0;
        end else if (r_q > V_HI) begin
            x_ten = X_MAX;
        end else begin
            x_ten = 15'(r_q - V_LO);
        end
        if (r_state == S_SCALE) begin
            mul_a = {7'd0, r_mag};
            mul_b = LOG_K;
        end else if (r_state == S_TEN) begin
            mul_a = {13'd0, x_ten};
            mul_b = RECIP10;
        end

        sq      = mul_p[33:16];
        sq_bit  = sq[17];
        frac_nx = {r_frac[14:0], sq_bit};
        d_log   = $signed({1'b0, r_la}) - $signed({1'b0, r_p, frac_nx});
        scaled  = 34'((mul_p + 56'd32768) >> 16);
        inv_t   = r_neg ? $signed({4'd0, INV_T0_Q40}) - $signed({2'd0, scaled})
                        : $signed({4'd0, INV_T0_Q40}) + $signed({2'd0, scaled});
        rem2    = {r_rem, 1'b0};
        q_bit   = (rem2 >= {1'b0, r_div});

        sp10 = 13'(r_sp) * 13'sd10;
        gap  = sp10 - 13'(r_tenths);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_raise_pend = raise_p && !raise_ok;
                    n_lower_pend = lower_p && !lower_ok;
                    if (raise_ok) begin
                        n_last_raise = i_in_data.time_us;
                    end
                    if (lower_ok) begin
                        n_last_lower = i_in_data.time_us;
                        n_sp = clamp_sp(sp_mid - $signed({5'd0, r_step}));
                    end else begin
                        n_sp = sp_mid[SP_W-1:0];
                    end
                    n_code  = 16'(i_in_data.adc_code);
                    n_fault = 1'b0;
                    n_cnt   = 5'd0;
                    n_frac  = 16'd0;
                    if (i_in_data.adc_code == '0) begin
                        n_fault  = 1'b1;
                        n_tenths = TEMP_MAX;
                        n_state  = S_DONE;
                    end else if (16'(i_in_data.adc_code) >= FULL_CODE) begin
                        n_fault  = 1'b1;
                        n_tenths = TEMP_MIN;
                        n_state  = S_DONE;
                    end else begin
                        n_p     = norm_p;
                        n_m     = 17'({1'b0, norm_x} << (5'd16 - {1'b0, norm_p}));
                        n_state = S_LOGA;
                    end
                end
            end
            S_LOGA, S_LOGB: begin
                n_m    = sq_bit ? sq[17:1] : sq[16:0];
                n_frac = frac_nx;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    n_cnt  = 5'd0;
                    n_frac = 16'd0;
                    if (r_state == S_LOGA) begin
                        n_la    = {r_p, frac_nx};
                        n_p     = norm_p;
                        n_m     = 17'({1'b0, norm_x} << (5'd16 - {1'b0, norm_p}));
                        n_state = S_LOGB;
                    end else begin
                        n_neg   = d_log[20];
                        n_mag   = d_log[20] ? 21'(-d_log) : 21'(d_log);
                        n_state = S_SCALE;
                    end
                end
            end
            S_SCALE: begin
                if (inv_t <= 36'sd0) begin
                    n_tenths = TEMP_MAX;
                    n_state  = S_DONE;
                end else begin
                    n_div   = inv_t[34:0];
                    n_rem   = DIV_INIT;
                    n_q     = 20'd0;
                    n_cnt   = 5'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = q_bit ? 35'(rem2 - {1'b0, r_div}) : rem2[34:0];
                n_q   = {r_q[18:0], q_bit};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = S_TEN;
                end
            end
            S_TEN: begin
                n_tenths = $signed({1'b0, mul_p[29:19]}) + TEMP_MIN;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.temperature_tenths = r_tenths;
                    n_out.alarm_setpoint     = r_sp;
                    n_out.alarm_active       = (13'(r_tenths) >= sp10);
                    n_out.led_bar = {gap <= 13'sd20, gap <= 13'sd100,
                                     gap <= 13'sd150, gap <= 13'sd200};
                    n_out.sensor_fault = r_fault;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_deb        <= DEB_RESET;
            r_step       <= STEP_RESET;
            r_sp         <= SP_RESET;
            r_raise_pend <= 1'b0;
            r_lower_pend <= 1'b0;
            r_last_raise <= '0;
            r_last_lower <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_sp         <= n_sp;
            r_raise_pend <= n_raise_pend;
            r_lower_pend <= n_lower_pend;
            r_last_raise <= n_last_raise;
            r_last_lower <= n_last_lower;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DEBOUNCE: r_deb  <= i_cfg_data;
                    CFG_STEP:     r_step <= i_cfg_data[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_m      <= n_m;
        r_frac   <= n_frac;
        r_p      <= n_p;
        r_la     <= n_la;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_tenths <= n_tenths;
        r_fault  <= n_fault;
        r_out    <= n_out;
    end

`ifndef NO_ASSERTIONS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a taken beat");

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sp >= -8'sd40) && (r_sp <= 8'sd125))
        else $error("setpoint out of range");

    a_fault_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.sensor_fault) |->
        (o_out_data.temperature_tenths == TEMP_MAX ||
         o_out_data.temperature_tenths == TEMP_MIN))
        else $error("fault beat without rail temperature");
`endif

endmodule
